// File: rtl/core/bpq_pkg.sv
// bpq_pkg: shared constants, codes and controller/datapath interface types
// for the bucket priority queue; no dependencies
package bpq_pkg;

	localparam int NUM_BUCKETS_DEF  = 16;
	localparam int BUCKET_DEPTH_DEF = 16;
	localparam int ENTRY_WIDTH_DEF  = 32;

	localparam int PRIO_W    = 8;
	localparam int ENTRY_W   = 32;
	localparam int S_TDATA_W = 40;   // priority_req, entry
	localparam int M_TDATA_W = 32;   // entry_out

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0]  REG_BUCKETS_IN_USE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  REG_BUCKET_CAPACITY = 1'b1;
	localparam logic [CFG_DATA_W-1:0] BUCKETS_IN_USE_RST  = 5'd16;
	localparam logic [CFG_DATA_W-1:0] BUCKET_CAPACITY_RST = 5'd16;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} bpq_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_FILL,
		ST_INS_SCAN,
		ST_INS_WRITE,
		ST_INS_OK,
		ST_EX_SCAN,
		ST_EX_POP,
		ST_EX_DATA,
		ST_FAIL
	} bpq_state_t;

	typedef struct packed {
		logic load;        // input beat taken
		logic fill_chk;    // latch fill count of the insert bucket
		logic ins_scan;    // duplicate search step
		logic ins_write;   // append entry, bump fill
		logic ex_scan;     // fill count search step
		logic ex_pop;      // drop fill, read top entry
		logic post;        // load output register
		logic post_ok;
		logic post_data;   // output word from store read data
	} bpq_cmd_t;

	typedef struct packed {
		logic is_extract;
		logic prio_ok;
		logic fill_full;
		logic dup;
		logic ins_done;
		logic ex_hit;
		logic ex_done;
		logic out_free;
	} bpq_sts_t;

endpackage

// File: rtl/core/bpq_ram.sv
// bpq_ram: generic single write port, single read port ram with registered read
// no dependencies
module bpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/bpq_ctrl.sv
// bpq_ctrl: sequencing state machine of the bucket priority queue
// depends on bpq_pkg for state, command and status types
module bpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bpq_pkg::bpq_sts_t sts,
	output bpq_pkg::bpq_cmd_t cmd
);
	import bpq_pkg::*;

	bpq_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.is_extract) begin
						state_nxt = ST_EX_SCAN;
					end else if (!sts.prio_ok) begin
						state_nxt = ST_FAIL;
					end else begin
						state_nxt = ST_INS_FILL;
					end
				end
			end
			ST_INS_FILL: begin
				state_nxt = sts.fill_full ? ST_FAIL : ST_INS_SCAN;
			end
			ST_INS_SCAN: begin
				if (sts.dup) begin
					state_nxt = ST_FAIL;
				end else if (sts.ins_done) begin
					state_nxt = ST_INS_WRITE;
				end
			end
			ST_INS_WRITE: state_nxt = ST_INS_OK;
			ST_EX_SCAN: begin
				if (sts.ex_hit) begin
					state_nxt = ST_EX_POP;
				end else if (sts.ex_done) begin
					state_nxt = ST_FAIL;
				end
			end
			ST_EX_POP: state_nxt = ST_EX_DATA;
			ST_INS_OK, ST_EX_DATA, ST_FAIL: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_INS_FILL:  cmd.fill_chk  = 1'b1;
			ST_INS_SCAN:  cmd.ins_scan  = 1'b1;
			ST_INS_WRITE: cmd.ins_write = 1'b1;
			ST_EX_SCAN:   cmd.ex_scan   = 1'b1;
			ST_EX_POP:    cmd.ex_pop    = 1'b1;
			ST_INS_OK: begin
				cmd.post    = sts.out_free;
				cmd.post_ok = 1'b1;
			end
			ST_EX_DATA: begin
				cmd.post      = sts.out_free;
				cmd.post_ok   = 1'b1;
				cmd.post_data = 1'b1;
			end
			ST_FAIL: cmd.post = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/core/bpq_dp.sv
// bpq_dp: datapath of the bucket priority queue: config registers, fill count
// and entry store rams, search counters, output register; uses bpq_pkg, bpq_ram
module bpq_dp #(
	parameter int NUM_BUCKETS  = bpq_pkg::NUM_BUCKETS_DEF,
	parameter int BUCKET_DEPTH = bpq_pkg::BUCKET_DEPTH_DEF,
	parameter int ENTRY_WIDTH  = bpq_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [bpq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpq_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input item
	input  logic                            in_opcode,
	input  logic [bpq_pkg::PRIO_W-1:0]      in_prio,
	input  logic [bpq_pkg::ENTRY_W-1:0]     in_entry,
	// result
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_ok,
	output logic [bpq_pkg::ENTRY_W-1:0]     out_entry,
	// controller
	input  bpq_pkg::bpq_cmd_t               cmd,
	output bpq_pkg::bpq_sts_t               sts
);
	import bpq_pkg::*;

	localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int EBW  = $clog2(NUM_BUCKETS + 1);
	localparam int FW   = $clog2(BUCKET_DEPTH + 1);
	localparam int SD   = NUM_BUCKETS * BUCKET_DEPTH;
	localparam int AW   = (SD > 1) ? $clog2(SD) : 1;
	localparam int IBW  = $clog2(SD + 1);
	localparam int CW   = (ENTRY_WIDTH < ENTRY_W) ? ENTRY_WIDTH : ENTRY_W;
	localparam int PCW  = ((PRIO_W > CFG_DATA_W) ? PRIO_W : CFG_DATA_W) + 2;
	localparam int FCW  = ((FW > CFG_DATA_W) ? FW : CFG_DATA_W) + 1;
	localparam int ECW  = ((EBW > CFG_DATA_W) ? EBW : CFG_DATA_W) + 1;

	// configuration registers
	logic [CFG_DATA_W-1:0] biu_q, cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			biu_q <= BUCKETS_IN_USE_RST;
			cap_q <= BUCKET_CAPACITY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BUCKETS_IN_USE:  biu_q <= cfg_data;
				REG_BUCKET_CAPACITY: cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item registers
	logic [ENTRY_WIDTH-1:0] word_q;
	logic [BW-1:0]          bucket_q;
	logic [AW-1:0]          base_q;
	logic [FW-1:0]          n_q;
	logic [FW-1:0]          idx_q;
	logic                   cmp_v_q;
	logic [EBW-1:0]         eb_q;
	logic [IBW-1:0]         issue_base_q;
	logic [BW-1:0]          chk_b_q;
	logic [AW-1:0]          chk_base_q;
	logic                   chk_v_q;

	logic [BW-1:0]  in_bucket;
	logic           prio_ok;
	logic           ins_issue, ex_issue;
	logic [FW-1:0]  fill_rd;
	logic           ex_hit;

	assign in_bucket = in_prio[BW-1:0];
	assign prio_ok   = (PCW'(in_prio) < PCW'(biu_q)) && (PCW'(in_prio) < PCW'(NUM_BUCKETS));
	assign ins_issue = cmd.ins_scan && (idx_q < n_q);
	assign ex_issue  = cmd.ex_scan && (ECW'(eb_q) < ECW'(biu_q))
		&& (ECW'(eb_q) < ECW'(NUM_BUCKETS));

	// fill count ram with per-bucket valid bits cleared at reset
	logic [NUM_BUCKETS-1:0] fill_valid_q;
	logic                   fill_vld_s1;
	logic                   fill_we, fill_re;
	logic [BW-1:0]          fill_waddr, fill_raddr;
	logic [FW-1:0]          fill_wdata, fill_rdata;

	assign fill_re    = (cmd.load && in_opcode == OP_INSERT && prio_ok) || ex_issue;
	assign fill_raddr = cmd.load ? in_bucket : eb_q[BW-1:0];
	assign fill_we    = cmd.ins_write || cmd.ex_pop;
	assign fill_waddr = bucket_q;
	assign fill_wdata = cmd.ins_write ? n_q + 1'b1 : n_q;
	assign fill_rd    = fill_vld_s1 ? fill_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_valid_q <= '0;
			fill_vld_s1  <= 1'b0;
		end else begin
			if (fill_we) begin
				fill_valid_q[fill_waddr] <= 1'b1;
			end
			if (fill_re) begin
				fill_vld_s1 <= fill_valid_q[fill_raddr];
			end
		end
	end

	bpq_ram #(
		.WIDTH (FW),
		.DEPTH (NUM_BUCKETS),
		.AW    (BW)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	// entry store, bucket b occupies words b*BUCKET_DEPTH upward
	logic                   st_re;
	logic [AW-1:0]          st_raddr, st_waddr;
	logic [ENTRY_WIDTH-1:0] st_rdata;

	assign st_waddr = base_q + AW'(n_q);
	assign st_re    = ins_issue || cmd.ex_pop;
	assign st_raddr = cmd.ex_pop ? st_waddr : base_q + AW'(idx_q);

	bpq_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (SD),
		.AW    (AW)
	) u_store_ram (
		.clk   (clk),
		.we    (cmd.ins_write),
		.waddr (st_waddr),
		.wdata (word_q),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	assign ex_hit = chk_v_q && (fill_rd != '0);

	// search counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cmp_v_q      <= 1'b0;
			eb_q         <= '0;
			issue_base_q <= '0;
			chk_v_q      <= 1'b0;
		end else if (cmd.load) begin
			idx_q        <= '0;
			cmp_v_q      <= 1'b0;
			eb_q         <= '0;
			issue_base_q <= '0;
			chk_v_q      <= 1'b0;
		end else begin
			cmp_v_q <= ins_issue;
			chk_v_q <= ex_issue;
			if (ins_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ex_issue) begin
				eb_q         <= eb_q + 1'b1;
				issue_base_q <= issue_base_q + IBW'(BUCKET_DEPTH);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q   <= ENTRY_WIDTH'(in_entry[CW-1:0]);
			bucket_q <= in_bucket;
			base_q   <= AW'(in_bucket * BUCKET_DEPTH);
		end
		if (cmd.fill_chk) begin
			n_q <= fill_rd;
		end
		if (ex_issue) begin
			chk_b_q    <= eb_q[BW-1:0];
			chk_base_q <= AW'(issue_base_q);
		end
		if (cmd.ex_scan && ex_hit) begin
			bucket_q <= chk_b_q;
			base_q   <= chk_base_q;
			n_q      <= fill_rd - 1'b1;
		end
	end

	// output register
	logic                out_v_q;
	logic                out_ok_q;
	logic [ENTRY_W-1:0]  out_entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.post) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_ok_q    <= cmd.post_ok;
			out_entry_q <= cmd.post_data ? ENTRY_W'(st_rdata[CW-1:0]) : '0;
		end
	end

	assign out_valid = out_v_q;
	assign out_ok    = out_ok_q;
	assign out_entry = out_entry_q;

	// status
	assign sts.is_extract = (in_opcode == OP_EXTRACT);
	assign sts.prio_ok    = prio_ok;
	assign sts.fill_full  = (FCW'(fill_rd) >= FCW'(cap_q))
		|| (FCW'(fill_rd) >= FCW'(BUCKET_DEPTH));
	assign sts.dup        = cmp_v_q && (st_rdata == word_q);
	assign sts.ins_done   = (idx_q == n_q) && !cmp_v_q;
	assign sts.ex_hit     = ex_hit;
	assign sts.ex_done    = !ex_issue && !chk_v_q;
	assign sts.out_free   = !out_v_q || out_ready;

endmodule

// File: rtl/core/bucket_priority_queue.sv
// bucket_priority_queue: top level, joins controller and datapath
// depends on bpq_pkg, bpq_ctrl, bpq_dp (and bpq_ram below it)
//
// usage
//   s_axis carries one command per beat: tuser is the opcode (insert or
//   extract), tdata[7:0] the priority, tdata[39:8] the entry word. m_axis
//   returns exactly one beat per command: tuser is ok, tdata the extracted
//   word (zero for inserts and failed extracts).
//   cfg_* writes buckets_in_use (index 0) and bucket_capacity (index 1);
//   cfg_ready is always high, writes are meant only while the queue is idle.
//   one command is in flight at a time. an insert's time from input beat to output
//   beat grows with n, the entries already held in the target bucket: the
//   duplicate search reads one stored entry per cycle from the store ram. an
//   extract's time grows with b, the buckets read before the first non-empty
//   one, one fill count read per cycle. rejects at the priority check skip the
//   fill count check and the search.
//   reset empties all buckets at once (per-bucket valid bits on the fill
//   counts), no clearing pass; the entry store itself is not cleared.
//   when m_axis stalls, the result waits in the output register; the next
//   command is still taken and worked on, but holds its own result until the
//   register has been delivered or is being delivered, which then stalls s_axis.
module bucket_priority_queue #(
	parameter int NUM_BUCKETS  = bpq_pkg::NUM_BUCKETS_DEF,
	parameter int BUCKET_DEPTH = bpq_pkg::BUCKET_DEPTH_DEF,
	parameter int ENTRY_WIDTH  = bpq_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bpq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bpq_pkg::CFG_DATA_W-1:0]   cfg_data,
	// command stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bpq_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // priority_req[7:0], entry[39:8]
	input  logic                             s_axis_tuser,  // opcode
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bpq_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // entry_out[31:0]
	output logic                             m_axis_tuser   // ok
);
	import bpq_pkg::*;

	bpq_cmd_t cmd;
	bpq_sts_t sts;

	// registers never block a write
	assign cfg_ready = 1'b1;

	bpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bpq_dp #(
		.NUM_BUCKETS  (NUM_BUCKETS),
		.BUCKET_DEPTH (BUCKET_DEPTH),
		.ENTRY_WIDTH  (ENTRY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_opcode (s_axis_tuser),
		.in_prio   (s_axis_tdata[PRIO_W-1:0]),
		.in_entry  (s_axis_tdata[PRIO_W +: ENTRY_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_ok    (m_axis_tuser),
		.out_entry (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: rtl/core/bpq_checker.sv
// bpq_checker: port-level assertions for bucket_priority_queue, bound to it
// depends on bpq_pkg and the top level's port names
module bpq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [bpq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic                           m_axis_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// failed commands, including failed inserts, never carry a word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("nonzero word on failed result");

	// one command in flight: busy right after a command beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command taken while busy");

endmodule

bind bucket_priority_queue bpq_checker u_bpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// File: sim/tb.sv
// tb: self-checking testbench for bucket_priority_queue, command stream in, result stream out
// depends on bpq_pkg and the bucket_priority_queue rtl; keeps its own shadow of buckets and fills
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpq_pkg::*;

	localparam int NB            = NUM_BUCKETS_DEF;
	localparam int DEPTH         = BUCKET_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 400;   // long result back-pressure stretch
	localparam int IDLE_LIMIT    = 5000;  // cycles with no beat anywhere before giving up
	localparam int MAX_PRINTS    = 100;

	typedef struct {
		bpq_op_t     op;
		logic [7:0]  prio;
		logic [31:0] word;
	} cmd_t;

	typedef struct {
		logic        ok;
		logic [31:0] word;
	} result_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_t;

	// dut ports, all inputs known from time zero
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // priority_req[7:0], entry[39:8]
	logic                  s_axis_tuser  = 1'b0; // opcode
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;         // entry_out[31:0]
	logic                  m_axis_tuser;         // ok

	// shadow of the queue state and its two registers
	logic [31:0]           shadow_store [NB][DEPTH];
	logic [4:0]            shadow_fill [NB];
	logic [4:0]            shadow_buckets  = BUCKETS_IN_USE_RST;
	logic [4:0]            shadow_capacity = BUCKET_CAPACITY_RST;

	cmd_t                  cmd_backlog[$];      // commands not yet taken by the dut
	result_t               awaited_results[$];  // predicted beats not yet seen
	logic [31:0]           recent_words[$];     // candidates for duplicate inserts
	cmd_t                  taken_cmd;
	result_t               seen_result;

	int                    mismatches    = 0;
	int                    results_seen  = 0;
	int                    cmds_taken    = 0;
	int                    settings_used = 1;
	int                    ins_stored    = 0;
	int                    ins_rejected  = 0;
	int                    ext_hit       = 0;
	int                    ext_empty     = 0;
	int                    idle_cycles   = 0;

	// sender burst state and receiver stall state
	int                    burst_left    = 8;
	int                    gap_left      = 0;
	int                    hold_ask      = 0;
	int                    hold_seen     = 0;
	int                    hold_left     = 0;
	int                    rx_left       = 0;
	int                    rx_tick       = 0;
	rx_mode_t              rx_mode       = RX_OPEN;

	bucket_priority_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	// one command against the shadow state; updates it and returns the beat to expect
	function automatic result_t predict_result(input cmd_t c);
		result_t r;
		int      nb_eff;
		int      cap_eff;
		int      n;
		bit      dup;
		bit      found;
		r.ok    = 1'b0;
		r.word  = '0;
		nb_eff  = (shadow_buckets > NB) ? NB : shadow_buckets;
		cap_eff = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
		if (c.op == OP_INSERT) begin
			// priority range, then room in the bucket, then duplicate word
			if (c.prio < nb_eff) begin
				n = shadow_fill[c.prio];
				if (n < cap_eff) begin
					dup = 1'b0;
					for (int i = 0; i < n; i++)
						if (shadow_store[c.prio][i] == c.word)
							dup = 1'b1;
					if (!dup) begin
						shadow_store[c.prio][n] = c.word;
						shadow_fill[c.prio]     = 5'(n + 1);
						r.ok                    = 1'b1;
					end
				end
			end
			if (r.ok)
				ins_stored++;
			else
				ins_rejected++;
		end else begin
			// lowest visible non-empty bucket, newest entry first
			found = 1'b0;
			for (int b = 0; b < nb_eff; b++) begin
				if (!found && shadow_fill[b] != 0) begin
					found          = 1'b1;
					n              = shadow_fill[b] - 1;
					shadow_fill[b] = 5'(n);
					r.ok           = 1'b1;
					r.word         = shadow_store[b][n];
				end
			end
			if (r.ok)
				ext_hit++;
			else
				ext_empty++;
		end
		return r;
	endfunction

	// command driver: bursts of beats with random gaps, changes on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			s_axis_tvalid <= 1'b0;
		end else if (cmd_backlog.size() > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tuser  <= cmd_backlog[0].op;
			s_axis_tdata  <= {cmd_backlog[0].word, cmd_backlog[0].prio};
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// result ready: own stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_ask) begin
			hold_seen = hold_ask;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(10, 80);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:   m_axis_tready <= (rx_tick % 3 != 0);
			endcase
		end
	end

	// register writes and command beats feed the shadow model at the edge they happen
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BUCKETS_IN_USE:  shadow_buckets  = cfg_data;
					REG_BUCKET_CAPACITY: shadow_capacity = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				taken_cmd.op   = bpq_op_t'(s_axis_tuser);
				taken_cmd.prio = s_axis_tdata[7:0];
				taken_cmd.word = s_axis_tdata[39:8];
				awaited_results.push_back(predict_result(taken_cmd));
				void'(cmd_backlog.pop_front());
				cmds_taken++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
				end
			end
		end
	end

	// result monitor: each beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result beat ok=%0b data=%h with nothing awaited",
					m_axis_tuser, m_axis_tdata));
			end else begin
				seen_result = awaited_results.pop_front();
				if (m_axis_tuser !== seen_result.ok)
					report_mismatch($sformatf("result %0d: ok %0b, predicted %0b",
						results_seen, m_axis_tuser, seen_result.ok));
				if (m_axis_tdata !== seen_result.word)
					report_mismatch($sformatf("result %0d: entry_out %h, predicted %h",
						results_seen, m_axis_tdata, seen_result.word));
			end
		end
	end

	// watchdog on beats of any kind
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
		    (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d commands queued, %0d awaited",
					idle_cycles, cmd_backlog.size(), awaited_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic push_cmd(input bpq_op_t op, input logic [7:0] prio, input logic [31:0] w);
		cmd_t c;
		c.op   = op;
		c.prio = prio;
		c.word = w;
		cmd_backlog.push_back(c);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// registers change only with the queue idle: drain, let the dut settle, then write
	task automatic apply_setting(input int buckets, input int cap);
		while (cmd_backlog.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write(REG_BUCKETS_IN_USE, buckets[4:0]);
		cfg_write(REG_BUCKET_CAPACITY, cap[4:0]);
		settings_used++;
	endtask

	// random extracts and inserts, the inserts mostly well formed with some duplicates and bad priorities
	task automatic run_phase(input int buckets, input int cap, input int count,
	                         input int ext_pct, input bit with_hold);
		int          nb_eff;
		int          pick;
		int          mark;
		logic [7:0]  prio;
		logic [31:0] w;
		apply_setting(buckets, cap);
		nb_eff = (buckets > NB) ? NB : buckets;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < ext_pct) begin
				push_cmd(OP_EXTRACT, 8'($urandom_range(0, 255)), $urandom);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 8 || nb_eff == 0)
					prio = 8'($urandom_range(0, 255));
				else if (pick < 13)
					prio = 8'(nb_eff);
				else
					prio = 8'($urandom_range(0, nb_eff - 1));
				pick = $urandom_range(0, 99);
				if (pick < 20 && recent_words.size() > 0)
					w = recent_words[$urandom_range(0, recent_words.size() - 1)];
				else if (pick < 26)
					w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 3);
				else
					w = $urandom;
				recent_words.push_back(w);
				if (recent_words.size() > 24)
					void'(recent_words.pop_front());
				push_cmd(OP_INSERT, prio, w);
			end
		end
		if (with_hold) begin
			// let some traffic run, then stop taking results while commands keep coming
			mark = results_seen;
			while (results_seen < mark + 20)
				@(posedge clk);
			hold_ask++;
		end
	endtask

	initial begin
		for (int b = 0; b < NB; b++) begin
			shadow_fill[b] = '0;
			for (int i = 0; i < DEPTH; i++)
				shadow_store[b][i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset setting: empty queue, duplicates, priority bounds, lifo order
		push_cmd(OP_EXTRACT, 8'd0,   32'h0);
		push_cmd(OP_INSERT,  8'd0,   32'h0000_0000);
		push_cmd(OP_INSERT,  8'd0,   32'h0000_0000);
		push_cmd(OP_INSERT,  8'd0,   32'hFFFF_FFFF);
		push_cmd(OP_INSERT,  8'd15,  32'h1234_5678);
		push_cmd(OP_INSERT,  8'd16,  32'h0000_0001);
		push_cmd(OP_INSERT,  8'd255, 32'hFFFF_FFFF);
		push_cmd(OP_INSERT,  8'd15,  32'h1234_5678);
		push_cmd(OP_INSERT,  8'd15,  32'h0000_0000); // same word, other bucket
		push_cmd(OP_INSERT,  8'd128, 32'hA5A5_A5A5);
		push_cmd(OP_EXTRACT, 8'd0,   32'h0);
		push_cmd(OP_EXTRACT, 8'd0,   32'h0);
		push_cmd(OP_EXTRACT, 8'hFF,  32'hFFFF_FFFF); // ignored fields at their top
		push_cmd(OP_EXTRACT, 8'd0,   32'h0);
		push_cmd(OP_EXTRACT, 8'd0,   32'h0);

		// directed, small setting: bucket full, priority at the bucket count
		apply_setting(3, 2);
		push_cmd(OP_INSERT,  8'd2, 32'd5);
		push_cmd(OP_INSERT,  8'd2, 32'd6);
		push_cmd(OP_INSERT,  8'd2, 32'd7);
		push_cmd(OP_INSERT,  8'd3, 32'd8);
		push_cmd(OP_INSERT,  8'd1, 32'd5);
		push_cmd(OP_EXTRACT, 8'd0, 32'd0);
		push_cmd(OP_EXTRACT, 8'd0, 32'd0);
		push_cmd(OP_EXTRACT, 8'd0, 32'd0);
		push_cmd(OP_EXTRACT, 8'd0, 32'd0);

		// random phases; state carries over so hidden buckets and over-full buckets occur
		run_phase(16, 16, 400, 45, 1'b1);
		run_phase(1,  1,  150, 40, 1'b0);
		run_phase(5,  3,  200, 35, 1'b0);
		run_phase(2,  16, 200, 50, 1'b0); // upper buckets hidden
		run_phase(0,  5,   60, 50, 1'b0); // nothing accepted, nothing seen
		run_phase(16, 0,   60, 50, 1'b0); // inserts refused, hidden entries back
		run_phase(31, 31, 300, 30, 1'b0); // both registers saturate
		run_phase(1,  16, 200, 25, 1'b0); // bucket 0 runs full
		run_phase(8,  2,  150, 40, 1'b0); // capacity below existing fills
		run_phase(16, 16, 230, 60, 1'b0);

		while (cmd_backlog.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d predicted results never arrived",
				awaited_results.size()));

		$display("covered %0d commands over %0d register settings, %0d results checked",
			cmds_taken, settings_used, results_seen);
		$display("inserts stored %0d, rejected %0d; extracts hit %0d, empty %0d",
			ins_stored, ins_rejected, ext_hit, ext_empty);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
